// File: design/msgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msgs_pkg: shared constants and types of the multi-stop gradient sampler
// Stop count, word layout, fixed-point widths and the sequencer state type.
// ----------------------------------------------------------------------------
package msgs_pkg;

  localparam int MAX_STOPS    = 7;
  localparam int CHANNEL_BITS = 12;

  // stop_count register is 3 bits wide
  localparam int COUNT_W   = 3;
  localparam int STOP_IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CFG_IDX_W = $clog2(MAX_STOPS + 1);
  localparam int WORD_W    = 64;
  localparam int POS_W     = 16;
  localparam int SLOT_W    = 12;
  localparam int COORD_W   = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = '0;

  // Q1.15 one
  localparam logic [POS_W-1:0] ONE_Q15 = 16'h8000;

  typedef logic [WORD_W-1:0]       stop_word_t;
  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LAST,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  // channel ch of a stop word: R, G, B, A from high to low slot
  function automatic chan_t stop_chan(input stop_word_t w, input logic [1:0] ch);
    logic [SLOT_W-1:0] slot;
    case (ch)
      2'd0:    slot = w[47:36];
      2'd1:    slot = w[35:24];
      2'd2:    slot = w[23:12];
      default: slot = w[11:0];
    endcase
    return slot[CHANNEL_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/multi_stop_gradient_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stop_gradient_sampler_unit: multi-stop linear color gradient sampler
// Clamps a Q1.15 coordinate, finds its segment, divides for the local
// fraction and interpolates RGBA one channel at a time on a shared multiplier.
// ----------------------------------------------------------------------------
// One request is worked on at a time. After acceptance the sequencer scans
// the stops one per cycle, reads the segment start, runs a restoring divider
// one quotient bit per cycle (skipped for an empty segment or a coordinate at
// its start) and then uses a single multiplier for the four channels, one
// channel after another, and then hands the result to the output register.
// With no stops the result goes straight to the handoff; past the last
// segment the last stop color is read and handed off.
// The handoff waits while an earlier result is still stalled at the output.
// The output register lets the next request be accepted while a finished
// result still waits to be taken.
module multi_stop_gradient_sampler_unit
  import msgs_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [WORD_W-1:0]           cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [COORD_W-1:0]   in_coord,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [CHANNEL_BITS-1:0]          out_red,
  output logic [CHANNEL_BITS-1:0]          out_green,
  output logic [CHANNEL_BITS-1:0]          out_blue,
  output logic [CHANNEL_BITS-1:0]          out_alpha
);

  // configuration registers
  logic [COUNT_W-1:0] stop_count_r;
  stop_word_t         stop_r [MAX_STOPS];

  // sequencer state
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [COUNT_W-1:0] i_r, i_nxt;
  logic [POS_W-1:0]   t_r, t_nxt;
  stop_word_t         w0_r, w0_nxt, w1_r, w1_nxt;
  logic [POS_W:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]   den_r, den_nxt;
  logic [POS_W-1:0]   q_r, q_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [POS_W-1:0]   f_r, f_nxt;
  logic [1:0]         ch_r, ch_nxt;
  chan_t              res_r [4];
  chan_t              res_nxt [4];

  // output register
  logic               out_valid_r, out_valid_nxt;
  chan_t              out_r [4];
  logic               out_load;

  // shared read port of the stop words
  logic [COUNT_W-1:0]    rd_sel;
  stop_word_t            rd_word;

  // divider step
  logic [POS_W:0]        div_trial;
  logic                  div_bit;

  // channel interpolation datapath
  chan_t                 c1, c2;
  logic signed [CHANNEL_BITS:0]   ch_diff;
  logic signed [CHANNEL_BITS+POS_W+1:0] ch_prod;
  logic signed [CHANNEL_BITS+POS_W+1:0] ch_round;
  chan_t                 ch_res;

  logic [COUNT_W-1:0]    cnt_sat;
  logic [POS_W-1:0]      coord_clamped;
  logic [POS_W-1:0]      p0, p1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      for (int k = 0; k < MAX_STOPS; k++) stop_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_STOP_COUNT) begin
        stop_count_r <= cfg_data[COUNT_W-1:0];
      end else if (32'(cfg_index) <= MAX_STOPS) begin
        stop_r[STOP_IDX_W'(cfg_index - 1'b1)] <= cfg_data;
      end
    end
  end

  // stop word read mux
  always_comb begin
    rd_word = '0;
    if (32'(rd_sel) < MAX_STOPS) rd_word = stop_r[STOP_IDX_W'(rd_sel)];
  end

  // saturated count and clamped coordinate
  assign cnt_sat = (32'(stop_count_r) > MAX_STOPS) ? COUNT_W'(MAX_STOPS) : stop_count_r;

  always_comb begin
    if (in_coord[COORD_W-1])           coord_clamped = '0;
    else if (in_coord[POS_W-1:0] > ONE_Q15) coord_clamped = ONE_Q15;
    else                               coord_clamped = in_coord[POS_W-1:0];
  end

  assign p0 = rd_word[63:48];
  assign p1 = w1_r[63:48];

  // restoring division, one quotient bit per step
  assign div_trial = (cnt_r == 4'd0) ? rem_r : {rem_r[POS_W-1:0], 1'b0};
  assign div_bit   = div_trial >= {1'b0, den_r};

  // one channel: c1 + floor(((c2 - c1) * f + 16384) / 32768)
  assign c1       = stop_chan(w0_r, ch_r);
  assign c2       = stop_chan(w1_r, ch_r);
  assign ch_diff  = $signed({1'b0, c2}) - $signed({1'b0, c1});
  assign ch_prod  = ch_diff * $signed({1'b0, f_r});
  assign ch_round = ch_prod + (CHANNEL_BITS + POS_W + 2)'(16384);
  assign ch_res   = c1 + chan_t'(ch_round >>> 15);

  // output handoff
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    t_nxt     = t_r;
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    f_nxt     = f_r;
    ch_nxt    = ch_r;
    for (int k = 0; k < 4; k++) res_nxt[k] = res_r[k];
    rd_sel    = i_r + 1'b1;
    in_stall  = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt = cnt_sat;
          i_nxt = '0;
          t_nxt = coord_clamped;
          if (cnt_sat == '0) begin
            // no stops: opaque black
            res_nxt[0] = '0;
            res_nxt[1] = '0;
            res_nxt[2] = '0;
            res_nxt[3] = '1;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        rd_sel = i_r + 1'b1;
        if ((i_r + 1'b1) >= n_r) begin
          state_nxt = ST_LAST;
        end else if (t_r <= rd_word[63:48]) begin
          w1_nxt    = rd_word;
          state_nxt = ST_LOAD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_LAST: begin
        // past the last segment: last stop color
        rd_sel = n_r - 1'b1;
        for (int k = 0; k < 4; k++) res_nxt[k] = stop_chan(rd_word, 2'(k));
        state_nxt = ST_DONE;
      end
      ST_LOAD: begin
        rd_sel = i_r;
        w0_nxt = rd_word;
        ch_nxt = '0;
        if (p1 <= p0 || t_r <= p0) begin
          f_nxt     = '0;
          state_nxt = ST_MUL;
        end else begin
          den_nxt   = p1 - p0;
          rem_nxt   = {1'b0, t_r - p0};
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_bit ? (div_trial - {1'b0, den_r}) : div_trial;
        q_nxt   = {q_r[POS_W-2:0], div_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) begin
          f_nxt     = ({q_r[POS_W-2:0], div_bit} > ONE_Q15) ? ONE_Q15
                                                            : {q_r[POS_W-2:0], div_bit};
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        res_nxt[ch_r] = ch_res;
        ch_nxt        = ch_r + 1'b1;
        if (ch_r == 2'd3) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)            out_valid_nxt = 1'b1;
    else if (!out_stall)     out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      ch_r        <= '0;
      i_r         <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      i_r         <= i_nxt;
      n_r         <= n_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    w0_r  <= w0_nxt;
    w1_r  <= w1_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    f_r   <= f_nxt;
    for (int k = 0; k < 4; k++) res_r[k] <= res_nxt[k];
    if (out_load) begin
      for (int k = 0; k < 4; k++) out_r[k] <= res_r[k];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];
  assign out_alpha = out_r[3];

endmodule
`default_nettype wire
